### hw/rtl/tspr_pkg.sv
// tspr_pkg: shared types, constants and helper functions for the tile and sprite renderer
// no dependencies

package tspr_pkg;

  localparam int TILE_ADDR_W = 13;
  localparam int TILE_MEM_BYTES = 8192;

  localparam logic [TILE_ADDR_W-1:0] MAP_LO_BASE = 13'h1800;
  localparam logic [TILE_ADDR_W-1:0] MAP_HI_BASE = 13'h1C00;
  localparam logic [TILE_ADDR_W-1:0] SIGNED_DATA_BASE = 13'h0800;
  localparam logic [TILE_ADDR_W-1:0] CLEAR_LAST = 13'h1FFF;
  localparam logic [TILE_ADDR_W-1:0] PATTERN_LAST = 13'h17FF;
  localparam logic [8:0] MAP_PATTERN_LAST = 9'd383;

  localparam logic [7:0] PATTERN_EVEN = 8'h55;
  localparam logic [7:0] PATTERN_ODD = 8'hAA;

  // lcd control bits
  localparam int LCDC_BG_EN = 0;
  localparam int LCDC_OBJ_EN = 1;
  localparam int LCDC_BG_MAP = 3;
  localparam int LCDC_TILE_UNSIGNED = 4;
  localparam int LCDC_WIN_EN = 5;
  localparam int LCDC_WIN_MAP = 6;
  localparam int LCDC_DISP_EN = 7;

  // sprite flag bits
  localparam int OBJ_FLAG_PAL = 4;
  localparam int OBJ_FLAG_XFLIP = 5;
  localparam int OBJ_FLAG_YFLIP = 6;

  localparam logic [7:0] LCDC_RESET = 8'h91;
  localparam logic [7:0] PAL_RESET = 8'hE4;

  // first sprite entry after reset: y, x, tile, flags in byte order
  localparam logic [31:0] OBJ0_RESET = {8'd0, 8'd1, 8'd50, 8'd50};

  typedef enum logic [1:0] {
    CMD_TILE_WR = 2'd0,
    CMD_OBJ_WR  = 2'd1,
    CMD_RENDER  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LCDC  = 3'd0,
    REG_SCX   = 3'd1,
    REG_SCY   = 3'd2,
    REG_WX    = 3'd3,
    REG_WY    = 3'd4,
    REG_BGP   = 3'd5,
    REG_OBP0  = 3'd6,
    REG_OBP1  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_LLO,
    ST_LHI,
    ST_LCOL,
    ST_SRD,
    ST_SCHK,
    ST_SHI,
    ST_SCOL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   en;
    logic [TILE_ADDR_W-1:0] addr;
    logic [7:0]             data;
  } tile_wr_t;

  function automatic logic [1:0] tile_colour(input logic [7:0] lo, input logic [7:0] hi,
                                             input logic [2:0] col);
    logic [2:0] sh;
    sh = 3'd7 - col;
    return {hi[sh], lo[sh]};
  endfunction

  function automatic logic [1:0] map_shade(input logic [7:0] pal, input logic [1:0] idx);
    return pal[{idx, 1'b0} +: 2];
  endfunction

  function automatic logic [7:0] grey_of_shade(input logic [1:0] s);
    logic [7:0] g;
    case (s)
      2'd0: g = 8'd255;
      2'd1: g = 8'd192;
      2'd2: g = 8'd96;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/tspr_ifs.sv
// tspr_ifs: valid/ready channel interfaces for items, results and register writes
// depends on nothing

interface tspr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [12:0] address;
  logic [7:0] write_data;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  modport source (output valid, cmd, address, write_data, pixel_x, pixel_y, input ready);
  modport sink (input valid, cmd, address, write_data, pixel_x, pixel_y, output ready);
endinterface

interface tspr_out_if;
  logic       valid;
  logic       ready;
  logic       updated;
  logic [1:0] shade;
  logic [7:0] grey_level;
  logic       from_sprite;
  modport source (output valid, updated, shade, grey_level, from_sprite, input ready);
  modport sink (input valid, updated, shade, grey_level, from_sprite, output ready);
endinterface

interface tspr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/tile_sprite_pixel_renderer.sv
// tile_sprite_pixel_renderer: top level, register file, sprite table and render sequencer
// depends on tspr_pkg, tspr_ifs and tspr_tile_mem

// Tile and sprite pixel renderer. Items on pix_in either write a tile-memory
// byte (cmd 0), write a sprite-table byte (cmd 1) or render one pixel (cmd 2);
// only a render gives a result on pix_out. A write leaves the sequencer idle.
// A render walks one shared tile-memory read port under a small sequencer:
// the background or window tile (map byte, then the two plane bytes, then the
// colour), then for each sprite entry a table read and a hit check, plus a
// second-plane read and a colour step for each sprite that covers the pixel,
// then a hand-off of the result. A render with the display off or off screen
// goes straight to the hand-off. After reset the block sweeps all 8192 bytes
// of the tile memory to load its power-up pattern and accepts no item meanwhile;
// register writes on cfg are taken at any time and should be made while idle.
module tile_sprite_pixel_renderer #(
  parameter int SPRITE_COUNT = 40,
  parameter int SCREEN_WIDTH = 160,
  parameter int SCREEN_HEIGHT = 144
) (
  input  logic         clk,
  input  logic         rst,
  tspr_in_if.sink      pix_in,
  tspr_out_if.source   pix_out,
  tspr_cfg_if.sink     cfg
);

  localparam int SI_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam logic [SI_W-1:0] SPR_LAST = SI_W'(SPRITE_COUNT - 1);
  localparam logic [12:0] SPR_BYTES = 13'(SPRITE_COUNT * 4);
  localparam logic [8:0] SCR_W = 9'(SCREEN_WIDTH);
  localparam logic [8:0] SCR_H = 9'(SCREEN_HEIGHT);

  // configuration registers
  logic [7:0] lcdc, scx, scy, wx, wy, bgp, obp0, obp1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcdc <= tspr_pkg::LCDC_RESET;
      scx <= '0;
      scy <= '0;
      wx <= '0;
      wy <= '0;
      bgp <= tspr_pkg::PAL_RESET;
      obp0 <= tspr_pkg::PAL_RESET;
      obp1 <= tspr_pkg::PAL_RESET;
    end else if (cfg.valid) begin
      case (tspr_pkg::reg_idx_t'(cfg.index))
        tspr_pkg::REG_LCDC: lcdc <= cfg.data;
        tspr_pkg::REG_SCX:  scx <= cfg.data;
        tspr_pkg::REG_SCY:  scy <= cfg.data;
        tspr_pkg::REG_WX:   wx <= cfg.data;
        tspr_pkg::REG_WY:   wy <= cfg.data;
        tspr_pkg::REG_BGP:  bgp <= cfg.data;
        tspr_pkg::REG_OBP0: obp0 <= cfg.data;
        tspr_pkg::REG_OBP1: obp1 <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer state and datapath registers
  tspr_pkg::state_t state, state_next;
  logic                 clearing;
  logic                 accept;
  logic [7:0]           px, py;
  logic [SI_W-1:0]      spr_idx;
  logic [12:0]          map_addr;
  logic [12:0]          taddr;
  logic [2:0]           lcol, lrow;
  logic [2:0]           scol;
  logic                 spal;
  logic [7:0]           lo;
  logic                 drawn, from_spr;
  logic [1:0]           shade;

  // tile memory
  tspr_pkg::tile_wr_t   tile_wr;
  logic [12:0]          tile_raddr;
  logic [7:0]           tile_rdata;

  tspr_tile_mem u_tile_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (tile_wr),
    .raddr    (tile_raddr),
    .rdata    (tile_rdata),
    .clearing (clearing)
  );

  assign pix_in.ready = (state == tspr_pkg::ST_IDLE) && !clearing;
  assign accept = pix_in.valid && pix_in.ready;

  assign tile_wr.en = accept && (tspr_pkg::cmd_t'(pix_in.cmd) == tspr_pkg::CMD_TILE_WR);
  assign tile_wr.addr = pix_in.address;
  assign tile_wr.data = pix_in.write_data;

  // sprite table: one word per entry, bytes y, x, tile, flags from the low end
  logic [31:0] spr_mem [SPRITE_COUNT];
  logic [31:0] spr_rdata;
  logic        spr_clearing;
  logic [SI_W-1:0] spr_clr_idx;
  logic        spr_we;

  assign spr_we = accept && (tspr_pkg::cmd_t'(pix_in.cmd) == tspr_pkg::CMD_OBJ_WR)
                  && (pix_in.address < SPR_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      spr_clearing <= 1'b1;
      spr_clr_idx <= '0;
    end else if (spr_clearing) begin
      spr_clr_idx <= spr_clr_idx + 1'b1;
      if (spr_clr_idx == SPR_LAST) begin
        spr_clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (spr_clearing) begin
      spr_mem[spr_clr_idx] <= (spr_clr_idx == '0) ? tspr_pkg::OBJ0_RESET : '0;
    end else if (spr_we) begin
      spr_mem[pix_in.address[SI_W+1:2]][{pix_in.address[1:0], 3'b000} +: 8]
        <= pix_in.write_data;
    end
    spr_rdata <= spr_mem[spr_idx];
  end

  // pixel setup at accept: visibility, and background or window coordinates
  logic       visible;
  logic       use_win;
  logic [8:0] wc;
  logic [7:0] wl;
  logic [7:0] lx, ly;
  logic       map_sel;

  always_comb begin
    visible = lcdc[tspr_pkg::LCDC_DISP_EN] && ({1'b0, pix_in.pixel_x} < SCR_W)
              && ({1'b0, pix_in.pixel_y} < SCR_H);
    wc = {1'b0, pix_in.pixel_x} + 9'd7 - {1'b0, wx};
    wl = pix_in.pixel_y - wy;
    use_win = lcdc[tspr_pkg::LCDC_WIN_EN] && (pix_in.pixel_y >= wy)
              && (({1'b0, pix_in.pixel_x} + 9'd7) >= {1'b0, wx});
    if (use_win) begin
      lx = wc[7:0];
      ly = wl;
      map_sel = lcdc[tspr_pkg::LCDC_WIN_MAP];
    end else begin
      lx = pix_in.pixel_x + scx;
      ly = pix_in.pixel_y + scy;
      map_sel = lcdc[tspr_pkg::LCDC_BG_MAP];
    end
  end

  // tile base from the map byte, unsigned or signed around the middle block
  logic [12:0] layer_taddr;
  always_comb begin
    if (lcdc[tspr_pkg::LCDC_TILE_UNSIGNED]) begin
      layer_taddr = {1'b0, tile_rdata, 4'b0000} + {9'd0, lrow, 1'b0};
    end else begin
      layer_taddr = tspr_pkg::SIGNED_DATA_BASE + {1'b0, tile_rdata ^ 8'h80, 4'b0000}
                    + {9'd0, lrow, 1'b0};
    end
  end

  // sprite hit test on the entry just read
  logic [9:0]  dy, dx;
  logic        hit;
  logic [2:0]  srow, scol_cur;
  logic [12:0] spr_taddr;
  logic [1:0]  lcolour, scolour;

  always_comb begin
    dy = {2'b00, py} + 10'd16 - {2'b00, spr_rdata[7:0]};
    dx = {2'b00, px} + 10'd8 - {2'b00, spr_rdata[15:8]};
    hit = (dy < 10'd8) && (dx < 10'd8);
    srow = spr_rdata[24 + tspr_pkg::OBJ_FLAG_YFLIP] ? ~dy[2:0] : dy[2:0];
    scol_cur = spr_rdata[24 + tspr_pkg::OBJ_FLAG_XFLIP] ? ~dx[2:0] : dx[2:0];
    spr_taddr = {1'b0, spr_rdata[23:16], 4'b0000} + {9'd0, srow, 1'b0};
    lcolour = tspr_pkg::tile_colour(lo, tile_rdata, lcol);
    scolour = tspr_pkg::tile_colour(lo, tile_rdata, scol);
  end

  // next state and tile read address
  always_comb begin
    state_next = state;
    tile_raddr = '0;
    case (state)
      tspr_pkg::ST_IDLE: begin
        if (accept && tspr_pkg::cmd_t'(pix_in.cmd) == tspr_pkg::CMD_RENDER) begin
          if (!visible) begin
            state_next = tspr_pkg::ST_DONE;
          end else if (lcdc[tspr_pkg::LCDC_BG_EN]) begin
            state_next = tspr_pkg::ST_MAP;
          end else if (lcdc[tspr_pkg::LCDC_OBJ_EN]) begin
            state_next = tspr_pkg::ST_SRD;
          end else begin
            state_next = tspr_pkg::ST_DONE;
          end
        end
      end
      tspr_pkg::ST_MAP: begin
        tile_raddr = map_addr;
        state_next = tspr_pkg::ST_LLO;
      end
      tspr_pkg::ST_LLO: begin
        tile_raddr = layer_taddr;
        state_next = tspr_pkg::ST_LHI;
      end
      tspr_pkg::ST_LHI: begin
        tile_raddr = taddr + 1'b1;
        state_next = tspr_pkg::ST_LCOL;
      end
      tspr_pkg::ST_LCOL: begin
        state_next = lcdc[tspr_pkg::LCDC_OBJ_EN] ? tspr_pkg::ST_SRD : tspr_pkg::ST_DONE;
      end
      tspr_pkg::ST_SRD: begin
        state_next = tspr_pkg::ST_SCHK;
      end
      tspr_pkg::ST_SCHK: begin
        tile_raddr = spr_taddr;
        if (hit) begin
          state_next = tspr_pkg::ST_SHI;
        end else if (spr_idx == SPR_LAST) begin
          state_next = tspr_pkg::ST_DONE;
        end else begin
          state_next = tspr_pkg::ST_SRD;
        end
      end
      tspr_pkg::ST_SHI: begin
        tile_raddr = taddr + 1'b1;
        state_next = tspr_pkg::ST_SCOL;
      end
      tspr_pkg::ST_SCOL: begin
        state_next = (spr_idx == SPR_LAST) ? tspr_pkg::ST_DONE : tspr_pkg::ST_SRD;
      end
      tspr_pkg::ST_DONE: begin
        if (!pix_out.valid || pix_out.ready) begin
          state_next = tspr_pkg::ST_IDLE;
        end
      end
      default: state_next = tspr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tspr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      tspr_pkg::ST_IDLE: begin
        px <= pix_in.pixel_x;
        py <= pix_in.pixel_y;
        spr_idx <= '0;
        drawn <= 1'b0;
        from_spr <= 1'b0;
        shade <= '0;
        lcol <= lx[2:0];
        lrow <= ly[2:0];
        map_addr <= (map_sel ? tspr_pkg::MAP_HI_BASE : tspr_pkg::MAP_LO_BASE)
                    + {3'b000, ly[7:3], lx[7:3]};
      end
      tspr_pkg::ST_LLO: begin
        taddr <= layer_taddr;
      end
      tspr_pkg::ST_LHI: begin
        lo <= tile_rdata;
      end
      tspr_pkg::ST_LCOL: begin
        shade <= tspr_pkg::map_shade(bgp, lcolour);
        drawn <= 1'b1;
      end
      tspr_pkg::ST_SCHK: begin
        taddr <= spr_taddr;
        scol <= scol_cur;
        spal <= spr_rdata[24 + tspr_pkg::OBJ_FLAG_PAL];
        if (!hit) begin
          spr_idx <= spr_idx + 1'b1;
        end
      end
      tspr_pkg::ST_SHI: begin
        lo <= tile_rdata;
      end
      tspr_pkg::ST_SCOL: begin
        spr_idx <= spr_idx + 1'b1;
        // colour 0 is transparent
        if (scolour != 2'd0) begin
          shade <= tspr_pkg::map_shade(spal ? obp1 : obp0, scolour);
          drawn <= 1'b1;
          from_spr <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  logic out_valid;
  assign pix_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tspr_pkg::ST_DONE && (!out_valid || pix_out.ready)) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tspr_pkg::ST_DONE && (!out_valid || pix_out.ready)) begin
      pix_out.updated <= drawn;
      pix_out.shade <= shade;
      pix_out.grey_level <= drawn ? tspr_pkg::grey_of_shade(shade) : 8'd0;
      pix_out.from_sprite <= from_spr;
    end
  end

endmodule

### hw/rtl/tspr_tile_mem.sv
// tspr_tile_mem: 8 KiB tile memory with registered read and a power-up fill sweep
// depends on tspr_pkg

module tspr_tile_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  tspr_pkg::tile_wr_t                  wr,
  input  logic [tspr_pkg::TILE_ADDR_W-1:0]    raddr,
  output logic [7:0]                          rdata,
  output logic                                clearing
);

  logic [7:0] mem [tspr_pkg::TILE_MEM_BYTES];
  logic [tspr_pkg::TILE_ADDR_W-1:0] clr_addr;
  logic [8:0] map_cnt;
  logic [7:0] fill_data;
  logic       we;
  logic [tspr_pkg::TILE_ADDR_W-1:0] waddr;
  logic [7:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      map_cnt <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == tspr_pkg::CLEAR_LAST) begin
        clearing <= 1'b0;
      end
      if (clr_addr == tspr_pkg::PATTERN_LAST || map_cnt == tspr_pkg::MAP_PATTERN_LAST) begin
        map_cnt <= '0;
      end else begin
        map_cnt <= map_cnt + 1'b1;
      end
    end
  end

  // test pattern, then the low byte of a count mod 384 in the low map, then zero
  always_comb begin
    if (clr_addr < tspr_pkg::MAP_LO_BASE) begin
      fill_data = clr_addr[1] ? tspr_pkg::PATTERN_ODD : tspr_pkg::PATTERN_EVEN;
    end else if (clr_addr < tspr_pkg::MAP_HI_BASE) begin
      fill_data = map_cnt[7:0];
    end else begin
      fill_data = '0;
    end
    we = clearing | wr.en;
    waddr = clearing ? clr_addr : wr.addr;
    wdata = clearing ? fill_data : wr.data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
